// ===== sv/elcsr_pkg.sv =====
// ============================================================================
// elcsr_pkg
// shared types and status codes for the edge list to csr encoder
// ============================================================================
package elcsr_pkg;

    localparam int unsigned NodeW   = 64;
    localparam int unsigned StatusW = 3;

    typedef enum logic [StatusW-1:0] {
        ST_OK       = 3'd0,
        ST_SELF     = 3'd1,
        ST_SRC_BACK = 3'd2,
        ST_DST_BACK = 3'd3,
        ST_DUP      = 3'd4
    } t_status;

    typedef enum logic {
        WM_64 = 1'b0,
        WM_32 = 1'b1
    } t_width_mode;

    typedef struct packed {
        logic [NodeW-1:0] source_node;
        logic [NodeW-1:0] dest_node;
    } t_edge;

    typedef struct packed {
        logic  valid;
        t_edge payload;
    } t_stage;

endpackage

// ===== sv/elcsr_edge_if.sv =====
// ============================================================================
// elcsr_edge_if
// edge channel: valid, ready and one edge per transfer
// ============================================================================
interface elcsr_edge_if;

    logic                          valid;
    logic                          ready;
    logic [elcsr_pkg::NodeW-1:0]   source_node;
    logic [elcsr_pkg::NodeW-1:0]   dest_node;

    modport source (output valid, output source_node, output dest_node, input ready);
    modport sink   (input valid, input source_node, input dest_node, output ready);

endinterface

// ===== sv/elcsr_result_if.sv =====
// ============================================================================
// elcsr_result_if
// result channel: status, column word, row index update and running totals
// ============================================================================
interface elcsr_result_if;

    logic                          valid;
    logic                          ready;
    logic [elcsr_pkg::StatusW-1:0] status;
    logic [elcsr_pkg::NodeW-1:0]   column_word;
    logic [elcsr_pkg::NodeW-1:0]   index_offset;
    logic [elcsr_pkg::NodeW-1:0]   index_repeat;
    logic [elcsr_pkg::NodeW-1:0]   edges_total;
    logic [elcsr_pkg::NodeW-1:0]   isolated_total;

    modport source (
        output valid, output status, output column_word, output index_offset,
        output index_repeat, output edges_total, output isolated_total,
        input ready
    );
    modport sink (
        input valid, input status, input column_word, input index_offset,
        input index_repeat, input edges_total, input isolated_total,
        output ready
    );

endinterface

// ===== sv/elcsr_cfg_if.sv =====
// ============================================================================
// elcsr_cfg_if
// configuration write channel for the width mode register
// ============================================================================
interface elcsr_cfg_if;

    logic valid;
    logic ready;
    logic width_mode;

    modport source (output valid, output width_mode, input ready);
    modport sink   (input valid, input width_mode, output ready);

endinterface

// ===== sv/edge_list_to_csr_encoder.sv =====
// ============================================================================
// edge_list_to_csr_encoder
// sorted edge list in, compressed sparse row column words and row index out
// ============================================================================
// path: an edge transfer goes through the input register, then the result register
// throughput: one edge per cycle unless the result channel stalls; set by the
//   single compare and add pass reading and updating node, offset and counts
// reset: synchronous, active low; clears control state, counters and width mode
// ============================================================================
module edge_list_to_csr_encoder (
    input  logic            i_clk,
    input  logic            i_rst_n,
    elcsr_edge_if.sink      i_edge,
    elcsr_cfg_if.sink       i_cfg,
    elcsr_result_if.source  o_result
);

    elcsr_pkg::t_stage w_stage;
    logic              w_take;

    elcsr_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_edge  (i_edge),
        .i_take  (w_take),
        .o_stage (w_stage)
    );

    elcsr_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_stage  (w_stage),
        .o_take   (w_take),
        .i_cfg    (i_cfg),
        .o_result (o_result)
    );

endmodule

// ===== sv/elcsr_in_reg.sv =====
// ============================================================================
// elcsr_in_reg
// input register stage, holds one edge until the core consumes it
// ============================================================================
module elcsr_in_reg (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    elcsr_edge_if.sink           i_edge,
    input  logic                 i_take,
    output elcsr_pkg::t_stage    o_stage
);

    logic             r_valid;
    elcsr_pkg::t_edge r_edge;
    logic             w_load;

    assign i_edge.ready = !r_valid || i_take;
    assign w_load       = i_edge.valid && i_edge.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_edge.source_node <= i_edge.source_node;
            r_edge.dest_node   <= i_edge.dest_node;
        end
    end

    assign o_stage.valid   = r_valid;
    assign o_stage.payload = r_edge;

endmodule

// ===== sv/elcsr_core.sv =====
// ============================================================================
// elcsr_core
// edge checks, csr state update and result register
// ============================================================================
module elcsr_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  elcsr_pkg::t_stage    i_stage,
    output logic                 o_take,
    elcsr_cfg_if.sink            i_cfg,
    elcsr_result_if.source       o_result
);

    logic [elcsr_pkg::NodeW-1:0] r_cur, n_cur;
    logic [elcsr_pkg::NodeW-1:0] r_last, n_last;
    logic [elcsr_pkg::NodeW-1:0] r_boff, n_boff;
    logic [elcsr_pkg::NodeW-1:0] r_ecnt, n_ecnt;
    logic [elcsr_pkg::NodeW-1:0] r_icnt, n_icnt;
    elcsr_pkg::t_width_mode      r_wmode;

    logic                        r_out_valid;
    elcsr_pkg::t_status          r_status, n_status;
    logic [elcsr_pkg::NodeW-1:0] r_col, n_col;
    logic [elcsr_pkg::NodeW-1:0] r_ioff, n_ioff;
    logic [elcsr_pkg::NodeW-1:0] r_irep, n_irep;
    logic [elcsr_pkg::NodeW-1:0] r_etot;
    logic [elcsr_pkg::NodeW-1:0] r_itot;

    logic [elcsr_pkg::NodeW-1:0] w_src, w_dst, w_gap;
    logic                        w_out_free;

    assign w_src      = i_stage.payload.source_node;
    assign w_dst      = i_stage.payload.dest_node;
    assign w_gap      = w_src - r_cur;
    assign w_out_free = !r_out_valid || o_result.ready;
    assign o_take     = i_stage.valid && w_out_free;

    assign i_cfg.ready = 1'b1;

    always_comb begin
        n_cur    = r_cur;
        n_last   = r_last;
        n_boff   = r_boff;
        n_ecnt   = r_ecnt;
        n_icnt   = r_icnt;
        n_status = elcsr_pkg::ST_OK;
        n_col    = '0;
        n_ioff   = '0;
        n_irep   = '0;
        if (w_src == w_dst) begin
            n_status = elcsr_pkg::ST_SELF;
        end else if (w_src < r_cur) begin
            n_status = elcsr_pkg::ST_SRC_BACK;
        end else if (w_src == r_cur && r_last > w_dst) begin
            n_status = elcsr_pkg::ST_DST_BACK;
        end else if (w_src == r_cur && r_last == w_dst) begin
            n_status = elcsr_pkg::ST_DUP;
        end else begin
            if (w_src != r_cur) begin
                // source advance, gap minus one nodes had no edges
                n_irep = w_gap;
                n_ioff = r_boff;
                n_icnt = r_icnt + w_gap - 64'd1;
                n_cur  = w_src;
            end
            if (r_wmode == elcsr_pkg::WM_32) begin
                n_col  = {32'd0, w_dst[31:0]};
                n_boff = r_boff + 64'd4;
            end else begin
                n_col  = w_dst;
                n_boff = r_boff + 64'd8;
            end
            n_last = w_dst;
            n_ecnt = r_ecnt + 64'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur   <= '0;
            r_last  <= '0;
            r_boff  <= '0;
            r_ecnt  <= '0;
            r_icnt  <= '0;
            r_wmode <= elcsr_pkg::WM_64;
        end else begin
            if (o_take) begin
                r_cur  <= n_cur;
                r_last <= n_last;
                r_boff <= n_boff;
                r_ecnt <= n_ecnt;
                r_icnt <= n_icnt;
            end
            if (i_cfg.valid) begin
                r_wmode <= elcsr_pkg::t_width_mode'(i_cfg.width_mode);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= i_stage.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_status <= n_status;
            r_col    <= n_col;
            r_ioff   <= n_ioff;
            r_irep   <= n_irep;
            r_etot   <= n_ecnt;
            r_itot   <= n_icnt;
        end
    end

    assign o_result.valid          = r_out_valid;
    assign o_result.status         = r_status;
    assign o_result.column_word    = r_col;
    assign o_result.index_offset   = r_ioff;
    assign o_result.index_repeat   = r_irep;
    assign o_result.edges_total    = r_etot;
    assign o_result.isolated_total = r_itot;

endmodule
